// ----- design/crkv_pkg.sv -----
// package for the clock-replacement key-value cache
// types, codes and default sizes; no dependencies
package crkv_pkg;
    localparam int ENTRIES_DEF = 16;
    localparam int KEY_BITS = 32;
    localparam int VALUE_BITS = 64;
    localparam int CAP_BITS = 5;

    typedef enum logic [1:0] {
        OP_GET = 2'd0, OP_SET = 2'd1, OP_FILL = 2'd2, OP_FLUSH = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        K_OK = 3'd0, K_READ = 3'd1, K_FETCH = 3'd2, K_NOTFOUND = 3'd3, K_WB = 3'd4
    } kind_t;

    typedef struct packed {
        logic [1:0]            operation;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
        logic                  found;
    } req_t;

    typedef struct packed {
        logic [2:0]            kind;
        logic [KEY_BITS-1:0]   key_res;
        logic [VALUE_BITS-1:0] value_res;
        logic                  last;
    } res_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_LOOK, ST_LOOKW, ST_DECIDE, ST_SWEEP, ST_SWEEPW, ST_VICT,
        ST_WRITE, ST_FLUSH, ST_FLUSHW, ST_EMIT
    } state_t;
endpackage

// ----- design/clock_replacement_kv_cache_unit.sv -----
// top level of the clock-replacement key-value cache
// depends on crkv_pkg; keys and values held in memories with registered reads
// Lookup reads the key memory once per entry in use, up to the capacity, and stops at
// a hit. A replacement sweep visits one slot per cycle, at most capacity+1 slots. A dirty
// victim is first sent out as a write-back result. Each result is held until m_ready. A
// flush sends one write-back result per dirty filled entry. Results leave through a
// single output register.
module clock_replacement_kv_cache_unit #(
    parameter int ENTRIES = crkv_pkg::ENTRIES_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  crkv_pkg::req_t               s_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output crkv_pkg::res_t               m_data,
    input  logic                         cfg_we,
    input  logic [crkv_pkg::CAP_BITS-1:0] cfg_wdata
);
    import crkv_pkg::*;
    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);

    logic [KEY_BITS-1:0]   key_mem [ENTRIES];
    logic [VALUE_BITS-1:0] val_mem [ENTRIES];
    logic [KEY_BITS-1:0]   key_rd_reg;
    logic [VALUE_BITS-1:0] val_rd_reg;
    logic [ENTRIES-1:0]    dirty_reg, dirty_next, ref_reg, ref_next;
    logic [CW-1:0]         fill_reg, fill_next;
    logic [IW-1:0]         hand_reg, hand_next;
    logic [CAP_BITS-1:0]   cap_reg;
    state_t                state_reg, state_next;
    req_t                  req_reg, req_next;
    logic [CW-1:0]         idx_reg, idx_next;
    logic                  hit_reg, hit_next;
    logic                  m_valid_reg, m_valid_next;
    res_t                  m_data_reg, m_data_next;
    logic [IW-1:0]         rd_addr;
    logic                  we;
    logic [IW-1:0]         wa;
    logic [KEY_BITS-1:0]   wk;
    logic [VALUE_BITS-1:0] wv;
    logic [CW-1:0]         cap, lim;
    logic                  out_free;

    always_comb begin
        if (cap_reg == '0) cap = CW'(1);
        else if (32'(cap_reg) > ENTRIES) cap = CW'(ENTRIES);
        else cap = CW'(cap_reg);
        lim = (fill_reg < cap) ? fill_reg : cap;
    end

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            key_mem[wa] <= wk;
            val_mem[wa] <= wv;
        end
        key_rd_reg <= key_mem[rd_addr];
        val_rd_reg <= val_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            dirty_reg   <= '0;
            ref_reg     <= '0;
            fill_reg    <= '0;
            hand_reg    <= '0;
            cap_reg     <= CAP_BITS'(16);
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            dirty_reg   <= dirty_next;
            ref_reg     <= ref_next;
            fill_reg    <= fill_next;
            hand_reg    <= hand_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) cap_reg <= cfg_wdata;
        end
        req_reg    <= req_next;
        idx_reg    <= idx_next;
        hit_reg    <= hit_next;
        m_data_reg <= m_data_next;
    end

    always_comb begin
        state_next   = state_reg;
        dirty_next   = dirty_reg;
        ref_next     = ref_reg;
        fill_next    = fill_reg;
        hand_next    = hand_reg;
        req_next     = req_reg;
        idx_next     = idx_reg;
        hit_next     = hit_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        rd_addr      = idx_reg[IW-1:0];
        we           = 1'b0;
        wa           = idx_reg[IW-1:0];
        wk           = req_reg.key;
        wv           = req_reg.value;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    req_next = s_data;
                    idx_next = '0;
                    hit_next = 1'b0;
                    if (op_t'(s_data.operation) == OP_FLUSH) state_next = ST_FLUSH;
                    else if (op_t'(s_data.operation) == OP_FILL && !s_data.found)
                        state_next = ST_EMIT;
                    else state_next = ST_LOOK;
                end
            end
            ST_LOOK: begin
                if (idx_reg >= lim) state_next = ST_DECIDE;
                else state_next = ST_LOOKW;
            end
            ST_LOOKW: begin
                if (key_rd_reg == req_reg.key) begin
                    hit_next   = 1'b1;
                    state_next = ST_DECIDE;
                end else begin
                    idx_next   = idx_reg + CW'(1);
                    state_next = ST_LOOK;
                end
            end
            ST_DECIDE: begin
                if (hit_reg) begin
                    ref_next[idx_reg[IW-1:0]] = 1'b1;
                    if (op_t'(req_reg.operation) == OP_SET
                        && dirty_reg[idx_reg[IW-1:0]]) begin
                        state_next = ST_VICT;
                    end else if (op_t'(req_reg.operation) == OP_SET) begin
                        state_next = ST_WRITE;
                    end else state_next = ST_EMIT;
                end else if (op_t'(req_reg.operation) == OP_GET) begin
                    state_next = ST_EMIT;
                end else if (fill_reg < cap) begin
                    idx_next   = fill_reg;
                    fill_next  = fill_reg + CW'(1);
                    state_next = ST_WRITE;
                end else begin
                    if (CW'(hand_reg) >= cap) hand_next = '0;
                    state_next = ST_SWEEP;
                end
            end
            ST_SWEEP: begin
                if (ref_reg[hand_reg]) begin
                    ref_next[hand_reg] = 1'b0;
                    hand_next = (CW'(hand_reg) + CW'(1) >= cap) ? '0 : hand_reg + IW'(1);
                end else begin
                    idx_next   = CW'(hand_reg);
                    rd_addr    = hand_reg;
                    state_next = dirty_reg[hand_reg] ? ST_SWEEPW : ST_WRITE;
                end
            end
            ST_SWEEPW: state_next = ST_VICT;
            ST_VICT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '{K_WB, key_rd_reg, val_rd_reg, 1'b0};
                    state_next   = ST_WRITE;
                end
            end
            ST_WRITE: begin
                we = 1'b1;
                ref_next[idx_reg[IW-1:0]]   = 1'b1;
                dirty_next[idx_reg[IW-1:0]] = (op_t'(req_reg.operation) == OP_SET);
                state_next = ST_EMIT;
            end
            ST_FLUSH: begin
                if (idx_reg >= fill_reg) state_next = ST_EMIT;
                else if (dirty_reg[idx_reg[IW-1:0]]) state_next = ST_FLUSHW;
                else idx_next = idx_reg + CW'(1);
            end
            ST_FLUSHW: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '{K_WB, key_rd_reg, val_rd_reg, 1'b0};
                    dirty_next[idx_reg[IW-1:0]] = 1'b0;
                    idx_next     = idx_reg + CW'(1);
                    state_next   = ST_FLUSH;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                    unique case (op_t'(req_reg.operation))
                        OP_GET: m_data_next = hit_reg
                            ? '{K_READ, req_reg.key, val_rd_reg, 1'b1}
                            : '{K_FETCH, req_reg.key, '0, 1'b1};
                        OP_SET: m_data_next = '{K_OK, req_reg.key, '0, 1'b1};
                        OP_FILL: begin
                            if (!req_reg.found)
                                m_data_next = '{K_NOTFOUND, req_reg.key, '0, 1'b1};
                            else if (hit_reg)
                                m_data_next = '{K_READ, req_reg.key, val_rd_reg, 1'b1};
                            else
                                m_data_next = '{K_READ, req_reg.key, req_reg.value, 1'b1};
                        end
                        OP_FLUSH: m_data_next = '{K_OK, '0, '0, 1'b1};
                        default: m_data_next = '{K_OK, '0, '0, 1'b1};
                    endcase
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CW'(ENTRIES)) else $error("fill count beyond entry count");
    a_no_out_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("result dropped");
    a_accept_only_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg != ST_IDLE))
        else $error("request not taken");
endmodule

// ----- verif/tb_clock_replacement_kv_cache_unit.sv -----
// testbench for the clock-replacement key-value cache top level
// depends on crkv_pkg and clock_replacement_kv_cache_unit; self-checking with its own cache model
`timescale 1ns / 100ps

module tb_clock_replacement_kv_cache_unit;
    import crkv_pkg::*;

    localparam int N = ENTRIES_DEF;
    localparam int CYCLE_LIMIT = 900000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    req_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    res_t m_data;
    logic cfg_we = 1'b0;
    logic [CAP_BITS-1:0] cfg_wdata = '0;

    // cache model state
    logic [KEY_BITS-1:0]   mdl_keys [N];
    logic [VALUE_BITS-1:0] mdl_vals [N];
    logic                  mdl_dirty [N];
    logic                  mdl_ref [N];
    int                    mdl_filled;
    int                    mdl_hand;
    logic [CAP_BITS-1:0]   mdl_cap;

    res_t pending_results [$];
    int   errors = 0;
    int   cycles = 0;
    bit   idle_on = 1'b1;
    logic [KEY_BITS-1:0] key_pool [8];

    always #2 aclk = ~aclk;

    clock_replacement_kv_cache_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    function automatic int eff_capacity();
        if (mdl_cap == 0) return 1;
        if (mdl_cap > N) return N;
        return int'(mdl_cap);
    endfunction

    function automatic void push_result(kind_t k, logic [KEY_BITS-1:0] key,
                                        logic [VALUE_BITS-1:0] val);
        res_t r;
        r.kind = k;
        r.key_res = key;
        r.value_res = val;
        r.last = 1'b0;
        pending_results.push_back(r);
    endfunction

    function automatic int find_slot(logic [KEY_BITS-1:0] key);
        int lim;
        lim = (mdl_filled < eff_capacity()) ? mdl_filled : eff_capacity();
        for (int i = 0; i < lim; i++)
            if (mdl_keys[i] == key) return i;
        return -1;
    endfunction

    function automatic void place_entry(logic [KEY_BITS-1:0] key,
                                        logic [VALUE_BITS-1:0] val, logic dirty);
        int cap;
        int idx;
        cap = eff_capacity();
        if (mdl_filled < cap) begin
            idx = mdl_filled;
            mdl_filled++;
        end else begin
            if (mdl_hand >= cap) mdl_hand = 0;
            while (mdl_ref[mdl_hand]) begin
                mdl_ref[mdl_hand] = 1'b0;
                mdl_hand = (mdl_hand + 1 >= cap) ? 0 : mdl_hand + 1;
            end
            idx = mdl_hand;
            if (mdl_dirty[idx]) push_result(K_WB, mdl_keys[idx], mdl_vals[idx]);
        end
        mdl_keys[idx] = key;
        mdl_vals[idx] = val;
        mdl_dirty[idx] = dirty;
        mdl_ref[idx] = 1'b1;
    endfunction

    function automatic void predict_request(req_t rq);
        int hit;
        case (op_t'(rq.operation))
            OP_GET: begin
                hit = find_slot(rq.key);
                if (hit >= 0) begin
                    mdl_ref[hit] = 1'b1;
                    push_result(K_READ, rq.key, mdl_vals[hit]);
                end else begin
                    push_result(K_FETCH, rq.key, '0);
                end
            end
            OP_SET: begin
                hit = find_slot(rq.key);
                if (hit >= 0) begin
                    if (mdl_dirty[hit]) push_result(K_WB, mdl_keys[hit], mdl_vals[hit]);
                    mdl_vals[hit] = rq.value;
                    mdl_dirty[hit] = 1'b1;
                    mdl_ref[hit] = 1'b1;
                end else begin
                    place_entry(rq.key, rq.value, 1'b1);
                end
                push_result(K_OK, rq.key, '0);
            end
            OP_FILL: begin
                if (!rq.found) begin
                    push_result(K_NOTFOUND, rq.key, '0);
                end else begin
                    hit = find_slot(rq.key);
                    if (hit >= 0) begin
                        mdl_ref[hit] = 1'b1;
                        push_result(K_READ, rq.key, mdl_vals[hit]);
                    end else begin
                        place_entry(rq.key, rq.value, 1'b0);
                        push_result(K_READ, rq.key, rq.value);
                    end
                end
            end
            default: begin
                for (int i = 0; i < mdl_filled; i++)
                    if (mdl_dirty[i]) begin
                        push_result(K_WB, mdl_keys[i], mdl_vals[i]);
                        mdl_dirty[i] = 1'b0;
                    end
                push_result(K_OK, '0, '0);
            end
        endcase
        pending_results[$].last = 1'b1;
    endfunction

    task automatic send_request(op_t op, logic [KEY_BITS-1:0] key,
                                logic [VALUE_BITS-1:0] val, logic fnd);
        req_t rq;
        while (idle_on && $urandom_range(99) < 20) @(posedge aclk);
        rq.operation = op;
        rq.key = key;
        rq.value = val;
        rq.found = fnd;
        s_data <= rq;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        predict_request(rq);
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic drain();
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (4 * N + 20) @(posedge aclk);
    endtask

    task automatic write_capacity(logic [CAP_BITS-1:0] c);
        drain();
        cfg_wdata <= c;
        cfg_we <= 1'b1;
        @(posedge aclk);
        cfg_we <= 1'b0;
        mdl_cap = c;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // result checker
    always @(posedge aclk) begin
        res_t want;
        cycles <= cycles + 1;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result kind=%0d key=%h value=%h last=%b", $time,
                         m_data.kind, m_data.key_res, m_data.value_res, m_data.last);
                errors <= errors + 1;
            end else begin
                want = pending_results.pop_front();
                if (m_data !== want) begin
                    $display("%0t: expected kind=%0d key=%h value=%h last=%b", $time,
                             want.kind, want.key_res, want.value_res, want.last);
                    $display("%0t: actual   kind=%0d key=%h value=%h last=%b", $time,
                             m_data.kind, m_data.key_res, m_data.value_res, m_data.last);
                    errors <= errors + 1;
                end
            end
        end
        m_ready <= idle_on ? ($urandom_range(99) >= 20) : 1'b1;
    end

    always @(posedge aclk) begin
        if (cycles >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic test_directed();
        send_request(OP_GET, '0, '0, 1'b0);
        send_request(OP_FILL, 32'h0, '0, 1'b0);
        send_request(OP_FILL, 32'hFFFF_FFFF, '1, 1'b1);
        send_request(OP_GET, 32'hFFFF_FFFF, '0, 1'b0);
        send_request(OP_SET, 32'h0, 64'h0, 1'b1);
        send_request(OP_SET, 32'h0, '1, 1'b0);
        send_request(OP_FILL, 32'h0, 64'h1234, 1'b1);
        send_request(OP_SET, 32'hA5A5_5A5A, 64'h5A5A_A5A5_0F0F_F0F0, 1'b0);
        send_request(OP_FLUSH, 32'h1, 64'h1, 1'b1);
        send_request(OP_FLUSH, '0, '0, 1'b0);
        send_request(OP_GET, 32'h0, '0, 1'b1);
    endtask

    task automatic test_eviction();
        write_capacity(5'd2);
        for (int i = 0; i < 8; i++)
            send_request(i % 2 ? OP_SET : OP_FILL, 32'h100 + i, rand64(), 1'b1);
        send_request(OP_GET, 32'h107, '0, 1'b0);
        write_capacity(5'd0);
        send_request(OP_SET, 32'h200, rand64(), 1'b0);
        send_request(OP_SET, 32'h201, rand64(), 1'b0);
        send_request(OP_FLUSH, '0, '0, 1'b0);
        write_capacity(5'd31);
        send_request(OP_FLUSH, '0, '0, 1'b0);
    endtask

    task automatic test_random(int count);
        logic [4:0] caps [5] = '{5'd16, 5'd3, 5'd1, 5'd9, 5'd20};
        int r;
        logic [KEY_BITS-1:0] k;
        for (int i = 0; i < count; i++) begin
            if (i % 80 == 0) begin
                write_capacity(caps[(i / 80) % 5]);
                for (int j = 0; j < 8; j++) key_pool[j] = $urandom;
            end
            idle_on = !(i >= 160 && i < 220);
            r = $urandom_range(99);
            k = ($urandom_range(9) < 8) ? key_pool[$urandom_range(7)] : $urandom;
            if (r < 35) send_request(OP_GET, k, rand64(), $urandom_range(1));
            else if (r < 65) send_request(OP_SET, k, rand64(), $urandom_range(1));
            else if (r < 93) send_request(OP_FILL, k, rand64(), $urandom_range(9) != 0);
            else send_request(OP_FLUSH, $urandom, rand64(), $urandom_range(1));
        end
        idle_on = 1'b1;
    endtask

    initial begin
        for (int i = 0; i < N; i++) begin
            mdl_dirty[i] = 1'b0;
            mdl_ref[i] = 1'b0;
            mdl_keys[i] = '0;
            mdl_vals[i] = '0;
        end
        mdl_filled = 0;
        mdl_hand = 0;
        mdl_cap = 5'd16;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_eviction();
        test_random(360);
        drain();
        if (errors == 0 && pending_results.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
